// ===== sv/fgr_pkg.sv =====
// Shared types and constants for the glyph ROM read framer.
package fgr_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int INDEX_W    = 13;
    localparam int PROD_W     = 20;

    localparam logic [7:0] OPCODE_READ = 8'h03;
    localparam logic [7:0] SYM_HI_MIN  = 8'hA1;
    localparam logic [7:0] SYM_HI_MAX  = 8'hA9;
    localparam logic [7:0] HZ_HI_MIN   = 8'hB0;
    localparam logic [7:0] HZ_HI_MAX   = 8'hF7;
    localparam logic [7:0] LO_MIN      = 8'hA1;
    localparam logic [7:0] ASC_MIN     = 8'h20;
    localparam logic [7:0] ASC_MAX     = 8'h7E;
    localparam logic [INDEX_W-1:0] ROW_CODES = 13'd94;
    localparam logic [INDEX_W-1:0] HZ_OFFSET = 13'd846;

    localparam logic [CFG_DATA_W-1:0] RST_HZ16  = 24'd182736;
    localparam logic [CFG_DATA_W-1:0] RST_HZ24  = 24'd426384;
    localparam logic [CFG_DATA_W-1:0] RST_HZ32  = 24'd974592;
    localparam logic [CFG_DATA_W-1:0] RST_ASC16 = 24'd0;
    localparam logic [CFG_DATA_W-1:0] RST_ASC24 = 24'd0;
    localparam logic [CFG_DATA_W-1:0] RST_ASC32 = 24'd0;

    localparam int NUM_BASES = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HZ16  = 3'd0,
        CFG_HZ24  = 3'd1,
        CFG_HZ32  = 3'd2,
        CFG_ASC16 = 3'd3,
        CFG_ASC24 = 3'd4,
        CFG_ASC32 = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SIZE_NONE   = 2'd0,
        SIZE_SMALL  = 2'd1,
        SIZE_MEDIUM = 2'd2,
        SIZE_LARGE  = 2'd3
    } t_size;

    // Decoded character, leaving stage one.
    typedef struct packed {
        logic               bad;
        logic               cjk;
        t_size              size;
        logic [INDEX_W-1:0] index;
    } t_dec;

    // Per-item flags that ride along with the address.
    typedef struct packed {
        logic       bad;
        logic [7:0] len;
    } t_glyph;

    function automatic logic [7:0] glyph_bytes(input logic cjk, input t_size size);
        logic [7:0] b;
        b = 8'd0;
        case (size)
            SIZE_SMALL:  b = cjk ? 8'd32  : 8'd16;
            SIZE_MEDIUM: b = cjk ? 8'd72  : 8'd48;
            SIZE_LARGE:  b = cjk ? 8'd128 : 8'd64;
            default:     b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/font_rom_glyph_read_framer_unit.sv =====
// Glyph ROM read framer: GB2312 / ASCII code to SPI read frame, top level.
// Each accepted character passes three pipeline stages (decode and index,
// index times glyph size, base add) and then a frame register that sends
// opcode 0x03 and the three address bytes, one result per cycle while
// i_ready is high; a code or size that is not recognized gives a single
// result with status set. A valid item gives four results, an invalid one
// one; the three pipeline stages keep taking items while the frame register
// drains until they fill, so the sustained rate is set by that single output
// port. The user must write the base address registers through the write
// port only while no item is in flight, which the block does not enforce;
// they reset to the standard ROM layout.
module font_rom_glyph_read_framer_unit #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fgr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fgr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_mode,
    input  logic [7:0]                         i_first_byte,
    input  logic [7:0]                         i_second_byte,
    input  logic [1:0]                         i_glyph_size,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [7:0]                         o_spi_byte,
    output logic [7:0]                         o_read_length,
    output logic                               o_status,
    output logic                               o_last
);

    logic [ADDRESS_BITS-1:0]   r_base [fgr_pkg::NUM_BASES];
    logic                      dec_valid;
    logic                      dec_ready;
    fgr_pkg::t_dec             dec;
    logic                      adr_valid;
    logic                      adr_ready;
    fgr_pkg::t_glyph           adr_glyph;
    logic [ADDRESS_BITS-1:0]   adr_addr;

    // Only the low address bits matter since the sum wraps at that width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base[fgr_pkg::CFG_HZ16]  <= ADDRESS_BITS'(fgr_pkg::RST_HZ16);
            r_base[fgr_pkg::CFG_HZ24]  <= ADDRESS_BITS'(fgr_pkg::RST_HZ24);
            r_base[fgr_pkg::CFG_HZ32]  <= ADDRESS_BITS'(fgr_pkg::RST_HZ32);
            r_base[fgr_pkg::CFG_ASC16] <= ADDRESS_BITS'(fgr_pkg::RST_ASC16);
            r_base[fgr_pkg::CFG_ASC24] <= ADDRESS_BITS'(fgr_pkg::RST_ASC24);
            r_base[fgr_pkg::CFG_ASC32] <= ADDRESS_BITS'(fgr_pkg::RST_ASC32);
        end else if (i_cfg_we) begin
            unique case (fgr_pkg::t_cfg_idx'(i_cfg_index))
                fgr_pkg::CFG_HZ16:  r_base[fgr_pkg::CFG_HZ16]  <= ADDRESS_BITS'(i_cfg_data);
                fgr_pkg::CFG_HZ24:  r_base[fgr_pkg::CFG_HZ24]  <= ADDRESS_BITS'(i_cfg_data);
                fgr_pkg::CFG_HZ32:  r_base[fgr_pkg::CFG_HZ32]  <= ADDRESS_BITS'(i_cfg_data);
                fgr_pkg::CFG_ASC16: r_base[fgr_pkg::CFG_ASC16] <= ADDRESS_BITS'(i_cfg_data);
                fgr_pkg::CFG_ASC24: r_base[fgr_pkg::CFG_ASC24] <= ADDRESS_BITS'(i_cfg_data);
                fgr_pkg::CFG_ASC32: r_base[fgr_pkg::CFG_ASC32] <= ADDRESS_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    fgr_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_first_byte  (i_first_byte),
        .i_second_byte (i_second_byte),
        .i_glyph_size  (i_glyph_size),
        .o_valid       (dec_valid),
        .i_ready       (dec_ready),
        .o_dec         (dec)
    );

    fgr_addr #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec),
        .i_base  (r_base),
        .o_valid (adr_valid),
        .i_ready (adr_ready),
        .o_glyph (adr_glyph),
        .o_addr  (adr_addr)
    );

    fgr_frame #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (adr_valid),
        .o_ready       (adr_ready),
        .i_glyph       (adr_glyph),
        .i_addr        (adr_addr),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_spi_byte    (o_spi_byte),
        .o_read_length (o_read_length),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ===== sv/fgr_decode.sv =====
// Stage one: classify the character code and compute its glyph index.
module fgr_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_mode,
    input  logic [7:0]                i_first_byte,
    input  logic [7:0]                i_second_byte,
    input  logic [1:0]                i_glyph_size,
    output logic                      o_valid,
    input  logic                      i_ready,
    output fgr_pkg::t_dec             o_dec
);

    logic                          r_valid;
    fgr_pkg::t_dec                 r_dec;
    fgr_pkg::t_dec                 n_dec;
    logic [7:0]                    hi;
    logic [7:0]                    lo;
    logic                          is_sym;
    logic                          is_hz;
    logic                          is_asc;
    logic [fgr_pkg::INDEX_W-1:0]   row;
    logic [fgr_pkg::INDEX_W-1:0]   col;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // String form: a byte below the symbol range is a lone ASCII code
        if (i_mode && (i_first_byte < fgr_pkg::SYM_HI_MIN)) begin
            hi = 8'd0;
            lo = i_first_byte;
        end else begin
            hi = i_first_byte;
            lo = i_second_byte;
        end
        is_sym = (hi >= fgr_pkg::SYM_HI_MIN) && (hi <= fgr_pkg::SYM_HI_MAX)
                 && (lo >= fgr_pkg::LO_MIN);
        is_hz  = (hi >= fgr_pkg::HZ_HI_MIN) && (hi <= fgr_pkg::HZ_HI_MAX)
                 && (lo >= fgr_pkg::LO_MIN);
        is_asc = (hi == 8'd0) && (lo >= fgr_pkg::ASC_MIN) && (lo <= fgr_pkg::ASC_MAX);
        row    = is_hz ? fgr_pkg::INDEX_W'(hi - fgr_pkg::HZ_HI_MIN)
                       : fgr_pkg::INDEX_W'(hi - fgr_pkg::SYM_HI_MIN);
        col    = fgr_pkg::INDEX_W'(lo - fgr_pkg::LO_MIN);

        n_dec.size = fgr_pkg::t_size'(i_glyph_size);
        n_dec.cjk  = is_sym || is_hz;
        n_dec.bad  = !(is_sym || is_hz || is_asc) || (n_dec.size == fgr_pkg::SIZE_NONE);
        if (n_dec.cjk) begin
            n_dec.index = fgr_pkg::INDEX_W'(row * fgr_pkg::ROW_CODES + col
                          + (is_hz ? fgr_pkg::HZ_OFFSET : '0));
        end else begin
            n_dec.index = fgr_pkg::INDEX_W'(lo - fgr_pkg::ASC_MIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// ===== sv/fgr_addr.sv =====
// Stages two and three: scale the glyph index and add the ROM base.
module fgr_addr #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  fgr_pkg::t_dec             i_dec,
    input  logic [ADDRESS_BITS-1:0]   i_base [fgr_pkg::NUM_BASES],
    output logic                      o_valid,
    input  logic                      i_ready,
    output fgr_pkg::t_glyph           o_glyph,
    output logic [ADDRESS_BITS-1:0]   o_addr
);

    logic                          r_valid_p;
    logic                          r_valid_a;
    fgr_pkg::t_glyph               r_glyph_p;
    fgr_pkg::t_glyph               r_glyph_a;
    logic [fgr_pkg::PROD_W-1:0]    r_prod;
    logic [ADDRESS_BITS-1:0]       r_base;
    logic [ADDRESS_BITS-1:0]       r_addr;
    logic                          ready_p;
    logic                          ready_a;
    logic [7:0]                    bytes;
    logic [ADDRESS_BITS-1:0]       n_base;

    assign ready_a = !r_valid_a || i_ready;
    assign ready_p = !r_valid_p || ready_a;
    assign o_ready = ready_p;

    always_comb begin
        bytes = fgr_pkg::glyph_bytes(i_dec.cjk, i_dec.size);
        unique case (i_dec.size)
            fgr_pkg::SIZE_MEDIUM: n_base = i_dec.cjk ? i_base[fgr_pkg::CFG_HZ24]
                                                     : i_base[fgr_pkg::CFG_ASC24];
            fgr_pkg::SIZE_LARGE:  n_base = i_dec.cjk ? i_base[fgr_pkg::CFG_HZ32]
                                                     : i_base[fgr_pkg::CFG_ASC32];
            default:              n_base = i_dec.cjk ? i_base[fgr_pkg::CFG_HZ16]
                                                     : i_base[fgr_pkg::CFG_ASC16];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid_a <= 1'b0;
        end else begin
            if (ready_p) begin
                r_valid_p <= i_valid;
            end
            if (ready_a) begin
                r_valid_a <= r_valid_p;
            end
        end
        if (i_valid && ready_p) begin
            r_prod        <= fgr_pkg::PROD_W'(i_dec.index * fgr_pkg::PROD_W'(bytes));
            r_base        <= n_base;
            r_glyph_p.bad <= i_dec.bad;
            r_glyph_p.len <= i_dec.bad ? 8'd0 : bytes;
        end
        if (r_valid_p && ready_a) begin
            // Wrap modulo the address width
            r_addr    <= ADDRESS_BITS'(r_prod) + r_base;
            r_glyph_a <= r_glyph_p;
        end
    end

    assign o_valid = r_valid_a;
    assign o_glyph = r_glyph_a;
    assign o_addr  = r_addr;

endmodule

// ===== sv/fgr_frame.sv =====
// Output stage: holds one item, sends a frame byte per cycle on i_ready.
module fgr_frame #(
    parameter int ADDRESS_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  fgr_pkg::t_glyph           i_glyph,
    input  logic [ADDRESS_BITS-1:0]   i_addr,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_spi_byte,
    output logic [7:0]                o_read_length,
    output logic                      o_status,
    output logic                      o_last
);

    typedef enum logic [1:0] {
        POS_OPCODE = 2'd0,
        POS_HIGH   = 2'd1,
        POS_MID    = 2'd2,
        POS_LOW    = 2'd3
    } t_pos;

    logic                          r_valid;
    t_pos                          r_pos;
    fgr_pkg::t_glyph               r_glyph;
    logic [fgr_pkg::CFG_DATA_W-1:0] r_addr;
    logic                          last;

    assign last    = r_glyph.bad || (r_pos == POS_LOW);
    assign o_ready = !r_valid || (i_ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= POS_OPCODE;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_pos   <= POS_OPCODE;
        end else if (i_ready) begin
            // advance to the next frame byte
            r_pos <= t_pos'(r_pos + 2'd1);
        end
        if (i_valid && o_ready) begin
            r_glyph <= i_glyph;
            // address bits above the configured width go out as zero
            r_addr  <= fgr_pkg::CFG_DATA_W'(i_addr);
        end
    end

    always_comb begin
        unique case (r_pos)
            POS_OPCODE: o_spi_byte = fgr_pkg::OPCODE_READ;
            POS_HIGH:   o_spi_byte = r_addr[23:16];
            POS_MID:    o_spi_byte = r_addr[15:8];
            default:    o_spi_byte = r_addr[7:0];
        endcase
        if (r_glyph.bad) begin
            o_spi_byte = 8'd0;
        end
    end

    assign o_valid       = r_valid;
    assign o_read_length = r_glyph.len;
    assign o_status      = r_glyph.bad;
    assign o_last        = last;

endmodule
